// ===== hw/rtl/multichannel_peak_rms_meter_assert.svh =====
// ============================================================================
// Assertion macros for the peak / RMS level meter
// Concurrent assertion shorthands that can be compiled out as a group.
// ============================================================================
`ifndef MULTICHANNEL_PEAK_RMS_METER_ASSERT_SVH
`define MULTICHANNEL_PEAK_RMS_METER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define MPRM_ASSERT_NOW(lbl, clk, rst, ant, con) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
      else $error("meter assertion failed");
// Next-cycle implication, disabled during reset.
`define MPRM_ASSERT_NEXT(lbl, clk, rst, ant, con) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
      else $error("meter assertion failed");
`else
`define MPRM_ASSERT_NOW(lbl, clk, rst, ant, con)
`define MPRM_ASSERT_NEXT(lbl, clk, rst, ant, con)
`endif

`endif

// ===== hw/rtl/mcprm_pkg.sv =====
// ============================================================================
// mcprm_pkg
// Shared types and constants of the peak / RMS level meter.
// ============================================================================
package mcprm_pkg;

   // log2 results are Q16: 6 integer bits and 16 fraction bits.
   localparam int LOG_FRAC_BITS = 16;
   localparam int LOG_W         = 6 + LOG_FRAC_BITS;

   // 100 * log10(2) in Q16.
   localparam logic [20:0] LOG_K_Q16 = 21'd1972830;

   localparam logic signed [9:0] LEVEL_FLOOR = -10'sd500;
   localparam logic [9:0]        FLOOR_MAG   = 10'd500;

   localparam logic [3:0] CSR_NUM_CHANNELS = 4'd0;
   localparam logic [3:0] CSR_HOLD_TICKS   = 4'd1;

   typedef enum logic [1:0] {
      LOG_IDLE,
      LOG_NORM,
      LOG_SQUARE
   } log_state_type;

   typedef struct packed {
      logic             done;
      logic [LOG_W-1:0] value;
   } log_result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FLOG_GO,
      ST_FLOG_WAIT,
      ST_READ,
      ST_FETCH,
      ST_ELOG_GO,
      ST_ELOG_WAIT,
      ST_PLOG_GO,
      ST_PLOG_WAIT,
      ST_CALC,
      ST_EMIT
   } meter_state_type;

endpackage

// ===== hw/rtl/mcprm_log2.sv =====
// ============================================================================
// mcprm_log2
// Iterative base-2 logarithm in Q16 of a 64-bit unsigned word: six
// normalizing shift steps, then sixteen squaring steps for the fraction.
// ============================================================================
module mcprm_log2 (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [63:0]                 value,
   output mcprm_pkg::log_result_type   result
);

   mcprm_pkg::log_state_type state_ff, state_in;

   logic [3:0]  step_ff, step_in;
   logic [63:0] norm_ff, norm_in;
   logic [5:0]  exp_ff, exp_in;
   logic [31:0] mant_ff, mant_in;
   logic [15:0] frac_ff, frac_in;

   logic [6:0]  shift;
   logic [63:0] product;
   logic [32:0] squared;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcprm_pkg::LOG_IDLE: begin
            if (start) state_in = mcprm_pkg::LOG_NORM;
         end
         mcprm_pkg::LOG_NORM: begin
            if (step_ff == 4'd5) state_in = mcprm_pkg::LOG_SQUARE;
         end
         mcprm_pkg::LOG_SQUARE: begin
            if (step_ff == 4'd15) state_in = mcprm_pkg::LOG_IDLE;
         end
         default: state_in = mcprm_pkg::LOG_IDLE;
      endcase
   end

   // Datapath of one step.
   always_comb begin
      shift   = 7'd32 >> step_ff[2:0];
      norm_in = norm_ff;
      exp_in  = exp_ff;
      if ((norm_ff >> (7'd64 - shift)) == 64'd0) begin
         norm_in = norm_ff << shift;
         exp_in  = exp_ff - shift[5:0];
      end
      product = mant_ff * mant_ff;
      squared = product[63:31];
      if (squared[32]) begin
         mant_in = squared[32:1];
         frac_in = {frac_ff[14:0], 1'b1};
      end else begin
         mant_in = squared[31:0];
         frac_in = {frac_ff[14:0], 1'b0};
      end
   end

   // Outputs.
   always_comb begin
      result.done  = (state_ff == mcprm_pkg::LOG_SQUARE) && (step_ff == 4'd15);
      result.value = {exp_ff, frac_in};
   end

   always_comb begin
      step_in = step_ff + 4'd1;
      if (state_in != state_ff) step_in = 4'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcprm_pkg::LOG_IDLE;
         step_ff  <= 4'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         mcprm_pkg::LOG_IDLE: begin
            norm_ff <= value;
            exp_ff  <= 6'd63;
            frac_ff <= 16'd0;
         end
         mcprm_pkg::LOG_NORM: begin
            norm_ff <= norm_in;
            exp_ff  <= exp_in;
            mant_ff <= norm_in[63:32];
         end
         mcprm_pkg::LOG_SQUARE: begin
            mant_ff <= mant_in;
            frac_ff <= frac_in;
         end
         default: begin
            frac_ff <= 16'd0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/multichannel_peak_rms_meter.sv =====
// ============================================================================
// multichannel_peak_rms_meter
// Per-channel peak and RMS level meter reporting in tenths of dBFS.
// ============================================================================
//  channel | direction | words                          | sideband
//  req_    | in        | audio sample or refresh tick   | tuser: func, tlast: frame_end
//  rsp_    | out       | one level report per channel   | tlast: last enabled channel
//  csr_    | in        | register write, index and data | always ready
//
// Samples are taken one per cycle while no tick is in progress: a two-stage
// read-modify-write on the accumulator memories, with forwarding between
// back-to-back samples. A tick holds the input until its last report is taken:
// one frame-count logarithm per tick and two per channel, all in the shared
// log2 unit. A stalled report holds the sequencer. Reset clears entry valid
// bits at once, so no clearing pass follows it.
module multichannel_peak_rms_meter #(
   parameter int CHANNELS    = 8,
   parameter int SAMPLE_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   // tdata fields from bit 0: channel (3), sample (SAMPLE_BITS), zero fill
   input  logic [((3 + SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser fields from bit 0: func (1)
   input  logic [0:0]  req_tuser,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata fields from bit 0: chan_out (3), rms_db (10), peak_db (10),
   // over_count (6), zero fill
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int NW  = $clog2(CHANNELS + 1);
   localparam int SB  = SAMPLE_BITS;
   localparam int PB  = SAMPLE_BITS - 1;
   localparam int DW  = 25;
   localparam logic signed [DW-1:0] LEVEL_OFFSET = DW'((2 * (SAMPLE_BITS - 1)) << 16);
   localparam logic [DW-1:0] FLOOR_LOG = DW'(20 << 16);

   function automatic logic signed [9:0] level_db(logic signed [DW-1:0] l, logic zero);
      logic [DW-1:0] mag;
      logic [41:0]   prod;
      logic [9:0]    r;
      mag  = DW'(-l);
      prod = 42'(mag[20:0]) * 42'(mcprm_pkg::LOG_K_Q16) + 42'h80000000;
      r    = prod[41:32];
      if (zero) return mcprm_pkg::LEVEL_FLOOR;
      if (!l[DW-1]) return 10'sd0;
      if (mag > FLOOR_LOG) return mcprm_pkg::LEVEL_FLOOR;
      if (r > mcprm_pkg::FLOOR_MAG) return mcprm_pkg::LEVEL_FLOOR;
      return $signed(10'd0 - r);
   endfunction

   // Configuration.
   logic [3:0] num_channels_ff;
   logic [5:0] hold_ticks_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_channels_ff <= 4'd2;
         hold_ticks_ff   <= 6'd10;
      end else if (csr_valid) begin
         unique case (csr_index)
            mcprm_pkg::CSR_NUM_CHANNELS: num_channels_ff <= csr_data[3:0];
            mcprm_pkg::CSR_HOLD_TICKS:   hold_ticks_ff   <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // Input fields.
   logic [2:0]    req_channel;
   logic [SB-1:0] req_sample;
   logic          req_func;
   logic          accept, sample_acc, tick_acc;
   logic [SB-1:0] mag;
   logic [PB-1:0] pk_sat;
   logic [CW-1:0] req_addr;
   logic          req_ok;

   assign req_channel = req_tdata[2:0];
   assign req_sample  = req_tdata[3 +: SB];
   assign req_func    = req_tuser[0];
   assign accept      = req_tvalid && req_tready;
   assign sample_acc  = accept && !req_func;
   assign tick_acc    = accept && req_func;
   assign mag         = req_sample[SB-1] ? (~req_sample + SB'(1)) : req_sample;
   assign pk_sat      = mag[SB-1] ? {PB{1'b1}} : mag[PB-1:0];
   assign req_addr    = CW'(req_channel);
   assign req_ok      = 32'(req_channel) < CHANNELS;

   // Sequencer state.
   mcprm_pkg::meter_state_type st_ff, st_in;
   logic [NW-1:0] ch_ff, ch_in;
   logic [NW-1:0] n_chan;

   assign n_chan = (32'(num_channels_ff) > CHANNELS) ? NW'(CHANNELS) : NW'(num_channels_ff);

   // Accumulator memories.
   logic [PB-1:0]  peak_mem_ff   [CHANNELS];
   logic [63:0]    energy_mem_ff [CHANNELS];
   logic [5:0]     hold_mem_ff   [CHANNELS];
   logic [CHANNELS-1:0] acc_vld_ff, hold_vld_ff;

   logic          rd_en;
   logic [CW-1:0] rd_addr;
   logic [PB-1:0] pk_rd_ff;
   logic [63:0]   en_rd_ff;
   logic [5:0]    hold_rd_ff;
   logic          acc_rd_vld_ff, hold_rd_vld_ff;

   // Sample stage.
   logic          s1_vld_ff;
   logic          s1_ok_ff;
   logic [CW-1:0] s1_addr_ff;
   logic [2*SB-1:0] s1_sq_ff;
   logic [PB-1:0] s1_pk_ff;
   logic          fwd_ff;
   logic [PB-1:0] fwd_pk_ff;
   logic [63:0]   fwd_en_ff;
   logic [PB-1:0] base_pk, new_pk;
   logic [63:0]   base_en, new_en;
   logic [64:0]   en_sum;
   logic          s1_wr;

   logic [31:0]   frame_count_ff;

   // Tick datapath.
   logic [63:0]   e_val_ff;
   logic [2*PB-1:0] psq_ff;
   logic [5:0]    h_ff;
   logic          rms_zero_ff, pk_zero_ff;
   logic [mcprm_pkg::LOG_W-1:0] lf_ff;
   logic signed [DW-1:0] rms_l_ff, pk_l_ff;
   logic          rsp_last_ff;
   logic [31:0]   rsp_data_ff;
   logic          clear_acc;

   logic          log_start;
   logic [63:0]   log_value;
   mcprm_pkg::log_result_type log_res;

   logic signed [9:0] rms_db, pk_db;
   logic [6:0]    hold_new;

   mcprm_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .value  (log_value),
      .result (log_res)
   );

   always_comb begin
      base_pk = fwd_ff ? fwd_pk_ff : (acc_rd_vld_ff ? pk_rd_ff : '0);
      base_en = fwd_ff ? fwd_en_ff : (acc_rd_vld_ff ? en_rd_ff : 64'd0);
      new_pk  = (s1_pk_ff > base_pk) ? s1_pk_ff : base_pk;
      en_sum  = {1'b0, base_en} + 65'(s1_sq_ff);
      new_en  = en_sum[64] ? {64{1'b1}} : en_sum[63:0];
      s1_wr   = s1_vld_ff && s1_ok_ff;
   end

   assign rd_en   = sample_acc || (st_ff == mcprm_pkg::ST_READ);
   assign rd_addr = (st_ff == mcprm_pkg::ST_IDLE) ? req_addr : ch_ff[CW-1:0];

   always_ff @(posedge clock) begin
      if (s1_wr) begin
         peak_mem_ff[s1_addr_ff]   <= new_pk;
         energy_mem_ff[s1_addr_ff] <= new_en;
      end
      if (rd_en) begin
         pk_rd_ff      <= peak_mem_ff[rd_addr];
         en_rd_ff      <= energy_mem_ff[rd_addr];
         acc_rd_vld_ff <= acc_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == mcprm_pkg::ST_CALC) hold_mem_ff[ch_ff[CW-1:0]] <= hold_new[5:0];
      if (rd_en) begin
         hold_rd_ff     <= hold_mem_ff[rd_addr];
         hold_rd_vld_ff <= hold_vld_ff[rd_addr];
      end
   end

   // Stage registers and forwarding of a write to the entry being read.
   always_ff @(posedge clock) begin
      s1_ok_ff   <= req_ok;
      s1_addr_ff <= req_addr;
      s1_sq_ff   <= mag * mag;
      s1_pk_ff   <= pk_sat;
      fwd_ff     <= s1_wr && (s1_addr_ff == req_addr);
      fwd_pk_ff  <= new_pk;
      fwd_en_ff  <= new_en;
   end

   assign clear_acc = (tick_acc && (n_chan == '0)) ||
                      ((st_ff == mcprm_pkg::ST_EMIT) && rsp_tready && rsp_last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff      <= 1'b0;
         acc_vld_ff     <= '0;
         hold_vld_ff    <= '0;
         frame_count_ff <= 32'd0;
      end else begin
         s1_vld_ff <= sample_acc;
         if (s1_wr) acc_vld_ff[s1_addr_ff] <= 1'b1;
         if (st_ff == mcprm_pkg::ST_CALC) hold_vld_ff[ch_ff[CW-1:0]] <= 1'b1;
         if (sample_acc && req_tlast && (frame_count_ff != {32{1'b1}})) begin
            frame_count_ff <= frame_count_ff + 32'd1;
         end
         // A tick's clear wins over the write of the sample just before it.
         if (clear_acc) begin
            acc_vld_ff     <= '0;
            frame_count_ff <= 32'd0;
         end
      end
   end

   // Next state.
   always_comb begin
      st_in = st_ff;
      ch_in = ch_ff;
      unique case (st_ff)
         mcprm_pkg::ST_IDLE: begin
            if (tick_acc && (n_chan != '0)) begin
               st_in = mcprm_pkg::ST_FLOG_GO;
               ch_in = '0;
            end
         end
         mcprm_pkg::ST_FLOG_GO:   st_in = mcprm_pkg::ST_FLOG_WAIT;
         mcprm_pkg::ST_FLOG_WAIT: if (log_res.done) st_in = mcprm_pkg::ST_READ;
         mcprm_pkg::ST_READ:      st_in = mcprm_pkg::ST_FETCH;
         mcprm_pkg::ST_FETCH:     st_in = mcprm_pkg::ST_ELOG_GO;
         mcprm_pkg::ST_ELOG_GO:   st_in = mcprm_pkg::ST_ELOG_WAIT;
         mcprm_pkg::ST_ELOG_WAIT: if (log_res.done) st_in = mcprm_pkg::ST_PLOG_GO;
         mcprm_pkg::ST_PLOG_GO:   st_in = mcprm_pkg::ST_PLOG_WAIT;
         mcprm_pkg::ST_PLOG_WAIT: if (log_res.done) st_in = mcprm_pkg::ST_CALC;
         mcprm_pkg::ST_CALC:      st_in = mcprm_pkg::ST_EMIT;
         mcprm_pkg::ST_EMIT: begin
            if (rsp_tready) begin
               if (rsp_last_ff) begin
                  st_in = mcprm_pkg::ST_IDLE;
               end else begin
                  st_in = mcprm_pkg::ST_READ;
                  ch_in = ch_ff + NW'(1);
               end
            end
         end
         default: st_in = mcprm_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_tready = (st_ff == mcprm_pkg::ST_IDLE);
      rsp_tvalid = (st_ff == mcprm_pkg::ST_EMIT);
      log_start  = (st_ff == mcprm_pkg::ST_FLOG_GO) || (st_ff == mcprm_pkg::ST_ELOG_GO) ||
                   (st_ff == mcprm_pkg::ST_PLOG_GO);
      log_value  = 64'(frame_count_ff);
      if (st_ff == mcprm_pkg::ST_ELOG_GO) log_value = e_val_ff;
      if (st_ff == mcprm_pkg::ST_PLOG_GO) log_value = 64'(psq_ff);
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= mcprm_pkg::ST_IDLE;
         ch_ff <= '0;
      end else begin
         st_ff <= st_in;
         ch_ff <= ch_in;
      end
   end

   // Level and overload hold of the current channel.
   always_comb begin
      rms_db = level_db(rms_l_ff, rms_zero_ff);
      pk_db  = level_db(pk_l_ff, pk_zero_ff);
      if (pk_db == 10'sd0) begin
         hold_new = 7'd1;
      end else if (h_ff != 6'd0) begin
         hold_new = {1'b0, h_ff} + 7'd1;
      end else begin
         hold_new = 7'd0;
      end
      if (hold_new >= {1'b0, hold_ticks_ff}) hold_new = 7'd0;
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         mcprm_pkg::ST_FETCH: begin
            e_val_ff    <= acc_rd_vld_ff ? en_rd_ff : 64'd0;
            psq_ff      <= acc_rd_vld_ff ? pk_rd_ff * pk_rd_ff : '0;
            h_ff        <= hold_rd_vld_ff ? hold_rd_ff : 6'd0;
            rms_zero_ff <= !acc_rd_vld_ff || (en_rd_ff == 64'd0) || (frame_count_ff == 32'd0);
            pk_zero_ff  <= !acc_rd_vld_ff || (pk_rd_ff == '0);
         end
         mcprm_pkg::ST_FLOG_WAIT: begin
            if (log_res.done) lf_ff <= log_res.value;
         end
         mcprm_pkg::ST_ELOG_WAIT: begin
            if (log_res.done) begin
               rms_l_ff <= $signed(DW'(log_res.value)) - $signed(DW'(lf_ff)) - LEVEL_OFFSET;
            end
         end
         mcprm_pkg::ST_PLOG_WAIT: begin
            if (log_res.done) pk_l_ff <= $signed(DW'(log_res.value)) - LEVEL_OFFSET;
         end
         mcprm_pkg::ST_CALC: begin
            rsp_data_ff <= {3'd0, hold_new[5:0], pk_db, rms_db, ch_ff[2:0]};
            rsp_last_ff <= (ch_ff + NW'(1)) == n_chan;
         end
         default: ;
      endcase
   end

   logic tick_done, in_log_wait, hold_ok;

   assign tick_done   = rsp_tvalid && rsp_tready && rsp_tlast;
   assign in_log_wait = (st_ff == mcprm_pkg::ST_FLOG_WAIT) ||
                        (st_ff == mcprm_pkg::ST_ELOG_WAIT) ||
                        (st_ff == mcprm_pkg::ST_PLOG_WAIT);
   assign hold_ok     = (rsp_tdata[28:23] == 6'd0) || (rsp_tdata[28:23] < hold_ticks_ff);

`include "multichannel_peak_rms_meter_assert.svh"

   `MPRM_ASSERT_NEXT(a_last_ends_tick, clock, reset, tick_done, st_ff == mcprm_pkg::ST_IDLE)
   `MPRM_ASSERT_NOW(a_log_done_awaited, clock, reset, log_res.done, in_log_wait)
   `MPRM_ASSERT_NOW(a_hold_below_limit, clock, reset, rsp_tvalid, hold_ok)

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Level meter testbench
// Drives samples and refresh ticks into the meter under several channel
// counts and hold lengths. Every report is checked against a bit-exact
// software level calculation kept alongside the stimulus.
// ============================================================================
module tb;

   localparam int NCH = 8;
   localparam int SBITS = 24;
   localparam logic [3:0] CSR_UNUSED = 4'd15;
   localparam logic [0:0] FUNC_SAMPLE = 1'b0;
   localparam logic [0:0] FUNC_TICK = 1'b1;
   localparam logic [63:0] FULL_SCALE = 64'd1 << (SBITS - 1);
   localparam int SETTLE_CYCLES = 600;

   typedef struct {
      logic [2:0]        chan;
      logic signed [9:0] rms;
      logic signed [9:0] peak;
      logic [5:0]        over;
      logic              last;
   } level_report_type;

   logic        clock;
   logic        reset;
   logic [31:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        req_tlast;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_valid;
   logic        csr_ready;
   logic [3:0]  csr_index;
   logic [7:0]  csr_data;

   // Meter state as predicted from the accepted words.
   logic [3:0]  chan_setting;
   logic [5:0]  hold_setting;
   logic [22:0] peak_acc [NCH];
   logic [63:0] energy_acc [NCH];
   logic [31:0] frames_seen;
   logic [5:0]  hold_cnt [NCH];

   level_report_type pending_reports[$];
   int  errors = 0;
   int  words_sent = 0;
   int  ticks_sent = 0;
   int  reports_seen = 0;
   int  overloads_seen = 0;
   bit  idle_on = 0;
   int  rsp_wait = 0;

   multichannel_peak_rms_meter uut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser), .req_tlast(req_tlast),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   // log2 in Q16: MSB index plus 16 fraction bits by repeated squaring.
   function automatic longint log2_fixed(logic [63:0] v);
      int          e;
      logic [63:0] m;
      longint      f;
      e = 63;
      f = 0;
      while (e > 0 && v[e] == 1'b0) e--;
      m = (v << (63 - e)) >> 32;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 31;
         f = f << 1;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            f = f | 1;
         end
      end
      return (longint'(e) << 16) + f;
   endfunction

   function automatic int dbfs_tenths(logic [63:0] power, logic [31:0] frames);
      longint      l;
      logic [63:0] mag;
      if (power == 0 || frames == 0) return -500;
      l = log2_fixed(power) - log2_fixed({32'd0, frames}) - (longint'(2 * (SBITS - 1)) << 16);
      if (l >= 0) return 0;
      mag = 64'(-l);
      if (mag > (64'd20 << 16)) return -500;
      mag = (mag * 64'd1972830 + (64'd1 << 31)) >> 32;
      if (mag > 64'd500) return -500;
      return -int'(mag);
   endfunction

   task automatic meter_reset_state();
      chan_setting = 4'd2;
      hold_setting = 6'd10;
      frames_seen = '0;
      for (int c = 0; c < NCH; c++) begin
         peak_acc[c] = '0;
         energy_acc[c] = '0;
         hold_cnt[c] = '0;
      end
   endtask

   task automatic meter_apply(logic func, logic [2:0] ch, logic [23:0] smp, logic fe);
      logic [63:0] mag;
      logic [63:0] sq;
      logic [64:0] sum;
      int          n;
      int          pk;
      level_report_type r;
      if (func == FUNC_SAMPLE) begin
         mag = smp[23] ? ((64'd1 << SBITS) - {40'd0, smp}) : {40'd0, smp};
         sq = mag * mag;
         if (mag > FULL_SCALE - 1) mag = FULL_SCALE - 1;
         if (mag[22:0] > peak_acc[ch]) peak_acc[ch] = mag[22:0];
         sum = {1'b0, energy_acc[ch]} + {1'b0, sq};
         energy_acc[ch] = sum[64] ? '1 : sum[63:0];
         if (fe && frames_seen != '1) frames_seen++;
         return;
      end
      n = chan_setting > NCH ? NCH : chan_setting;
      for (int c = 0; c < n; c++) begin
         pk = dbfs_tenths({41'd0, peak_acc[c]} * {41'd0, peak_acc[c]}, 32'd1);
         if (pk >= 0) hold_cnt[c] = 6'd1;
         else if (hold_cnt[c] > 0) hold_cnt[c]++;
         if (hold_cnt[c] >= hold_setting) hold_cnt[c] = '0;
         r.chan = 3'(c);
         r.rms = 10'(dbfs_tenths(energy_acc[c], frames_seen));
         r.peak = 10'(pk);
         r.over = hold_cnt[c];
         r.last = (c + 1 == n);
         pending_reports = {pending_reports, r};
      end
      for (int c = 0; c < NCH; c++) begin
         peak_acc[c] = '0;
         energy_acc[c] = '0;
      end
      frames_seen = '0;
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // Sends one word; valid stays high when the next word follows at once.
   task automatic send_word(logic func, logic [2:0] ch, logic [23:0] smp, logic fe);
      int gap;
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tlast <= fe;
      req_tdata <= {5'd0, smp, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      meter_apply(func, ch, smp, fe);
      words_sent++;
      if (func == FUNC_TICK) ticks_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_reports.size() > 0) @(posedge clock);
      // A tick with no enabled channel reports nothing; it only clears the accumulators.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [3:0] idx, logic [7:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == mcprm_pkg::CSR_NUM_CHANNELS) chan_setting = value[3:0];
      else if (idx == mcprm_pkg::CSR_HOLD_TICKS) hold_setting = value[5:0];
   endtask

   function automatic logic [23:0] pick_sample();
      logic [23:0] v;
      case ($urandom_range(0, 6))
         0: v = 24'h7FFFFF;
         1: v = 24'h800000;
         2: v = 24'($urandom_range(0, 255));
         3: v = 24'($urandom_range(0, 65535)) << $urandom_range(0, 8);
         4: v = 24'h7FFFFF - 24'($urandom_range(0, 4095));
         default: v = 24'($urandom);
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   // Results are taken with random stalls after each report while idle_on is set.
   always @(posedge clock) begin : rsp_side
      int n;
      if (reset) begin
         rsp_tready <= 1'b1;
         rsp_wait <= 0;
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else if (rsp_tvalid && rsp_tready) begin
         n = idle_on ? $urandom_range(0, 17) : 0;
         rsp_wait <= n;
         rsp_tready <= (n == 0);
      end
   end

   always @(posedge clock) begin : report_check
      level_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         reports_seen++;
         if (pending_reports.size() == 0) begin
            report_mismatch("unexpected report, channel", rsp_tdata[2:0], -1);
         end else begin
            want = pending_reports.pop_front();
            if (want.over != 0) overloads_seen++;
            if (rsp_tdata[2:0] !== want.chan)
               report_mismatch("chan_out", rsp_tdata[2:0], want.chan);
            if ($signed(rsp_tdata[12:3]) !== want.rms)
               report_mismatch("rms_db", $signed(rsp_tdata[12:3]), want.rms);
            if ($signed(rsp_tdata[22:13]) !== want.peak)
               report_mismatch("peak_db", $signed(rsp_tdata[22:13]), want.peak);
            if (rsp_tdata[28:23] !== want.over)
               report_mismatch("over_count", rsp_tdata[28:23], want.over);
            if (rsp_tlast !== want.last)
               report_mismatch("last", rsp_tlast, want.last);
         end
      end
   end

   task automatic test_directed_levels();
      send_word(FUNC_TICK, 3'd0, 24'd0, 1'b0);          // silence
      send_word(FUNC_SAMPLE, 3'd0, 24'h7FFFFF, 1'b0);   // positive full scale
      send_word(FUNC_SAMPLE, 3'd1, 24'h800000, 1'b1);   // most negative sample
      send_word(FUNC_TICK, 3'd5, 24'hFFFFFF, 1'b1);
      send_word(FUNC_SAMPLE, 3'd0, 24'd1, 1'b1);        // far below the floor
      send_word(FUNC_SAMPLE, 3'd1, 24'd0, 1'b0);
      send_word(FUNC_TICK, 3'd0, 24'd0, 1'b0);
      // More samples than frames on channel 0 drives RMS above 0 dB.
      send_word(FUNC_SAMPLE, 3'd0, 24'h7FFFFF, 1'b0);
      send_word(FUNC_SAMPLE, 3'd0, 24'h800001, 1'b0);
      send_word(FUNC_SAMPLE, 3'd0, 24'h7FFFFF, 1'b1);
      send_word(FUNC_SAMPLE, 3'd7, 24'h400000, 1'b1);   // unreported channel
      send_word(FUNC_TICK, 3'd0, 24'd0, 1'b0);
      // Energy without any frame end reports the floor.
      send_word(FUNC_SAMPLE, 3'd1, 24'h123456, 1'b0);
      send_word(FUNC_TICK, 3'd0, 24'd0, 1'b0);
      send_word(FUNC_SAMPLE, 3'd0, 24'h000800, 1'b0);   // near -50 dB
      send_word(FUNC_SAMPLE, 3'd1, 24'hFFF6A0, 1'b1);
      send_word(FUNC_SAMPLE, 3'd0, 24'h00A000, 1'b0);
      send_word(FUNC_SAMPLE, 3'd1, 24'h2D4000, 1'b1);
      send_word(FUNC_TICK, 3'd0, 24'd0, 1'b0);
      send_word(FUNC_TICK, 3'd0, 24'd0, 1'b0);          // overload hold counts up
      wait_drained();
   endtask

   task automatic run_frames(int count);
      int n;
      int sent;
      sent = 0;
      n = chan_setting == 0 ? 1 : (chan_setting > NCH ? NCH : chan_setting);
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_word(FUNC_SAMPLE, 3'($urandom), 24'($urandom), 1'($urandom));
            sent++;
         end else begin
            for (int c = 0; c < n; c++)
               send_word(FUNC_SAMPLE, 3'(c), pick_sample(), c == n - 1);
            sent += n;
         end
         if ($urandom_range(0, 3) == 0) begin
            send_word(FUNC_TICK, 3'($urandom), 24'($urandom), 1'($urandom));
            sent++;
         end
         if ($urandom_range(0, 40) == 0) begin
            req_tvalid <= 1'b0;
            while (pending_reports.size() > 0) @(posedge clock);
         end
      end
      send_word(FUNC_TICK, 3'd0, 24'd0, 1'b0);
   endtask

   task automatic test_channel_counts();
      write_reg(mcprm_pkg::CSR_NUM_CHANNELS, 8'd8);
      idle_on = 1;
      run_frames(70);
      write_reg(mcprm_pkg::CSR_NUM_CHANNELS, 8'd1);
      run_frames(30);
      write_reg(mcprm_pkg::CSR_NUM_CHANNELS, 8'd15);
      idle_on = 0;
      run_frames(40);
      write_reg(mcprm_pkg::CSR_NUM_CHANNELS, 8'd0);
      run_frames(15);
      write_reg(CSR_UNUSED, 8'hFF);
      write_reg(mcprm_pkg::CSR_NUM_CHANNELS, 8'd5);
      idle_on = 1;
      run_frames(40);
   endtask

   task automatic test_hold_lengths();
      write_reg(mcprm_pkg::CSR_HOLD_TICKS, 8'd1);
      run_frames(35);
      write_reg(mcprm_pkg::CSR_HOLD_TICKS, 8'd50);
      write_reg(mcprm_pkg::CSR_NUM_CHANNELS, 8'd3);
      run_frames(60);
      write_reg(mcprm_pkg::CSR_HOLD_TICKS, 8'd63);
      idle_on = 0;
      run_frames(25);
      write_reg(mcprm_pkg::CSR_HOLD_TICKS, 8'd0);
      idle_on = 1;
      run_frames(25);
      write_reg(mcprm_pkg::CSR_HOLD_TICKS, 8'd3);
      write_reg(mcprm_pkg::CSR_NUM_CHANNELS, 8'd8);
      run_frames(40);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      meter_reset_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_levels();
      test_channel_counts();
      test_hold_lengths();
      wait_drained();
      $display("covered %0d words including %0d ticks, %0d level reports checked",
               words_sent, ticks_sent, reports_seen);
      $display("%0d reports showed an active overload hold", overloads_seen);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
